>>> rtl/duration_string_to_seconds_top_macros.svh
// Assertion macros for the duration string parser checker.
// Included by the checker file; expects clk and arst_n in scope.
`ifndef DURATION_STRING_TO_SECONDS_TOP_MACROS_SVH
`define DURATION_STRING_TO_SECONDS_TOP_MACROS_SVH

// Check a property at every clock edge outside reset
`define DSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included
`define DSS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dss_pkg.sv
// Shared types and constants for the duration string parser.
// No dependencies; used by the interfaces, the top level and the checker.
package dss_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_DIGIT = 2'd1,
		ST_BAD_UNIT = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// Default unit register codes
	localparam logic [1:0] UNIT_SEC  = 2'd0;
	localparam logic [1:0] UNIT_MIN  = 2'd1;
	localparam logic [1:0] UNIT_HOUR = 2'd2;
	localparam logic [1:0] UNIT_DAY  = 2'd3;

	// Seconds per unit
	localparam int unsigned SCALE_W = 17;
	localparam logic [SCALE_W-1:0] SCALE_SEC  = 17'd1;
	localparam logic [SCALE_W-1:0] SCALE_MIN  = 17'd60;
	localparam logic [SCALE_W-1:0] SCALE_HOUR = 17'd3600;
	localparam logic [SCALE_W-1:0] SCALE_DAY  = 17'd86400;

	// Largest magnitude any intermediate value may reach
	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

	// Character codes
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_S     = 8'h73;

	// Parse state of one string
	typedef struct packed {
		logic [31:0] acc;
		logic [31:0] total;
		logic        neg;
		logic        seen;
		logic        at_start;
		status_t     err;
	} parse_t;

	localparam parse_t PARSE_CLEAR = '{
		acc: 32'd0, total: 32'd0, neg: 1'b0, seen: 1'b0, at_start: 1'b1, err: ST_OK
	};

	// Map a default unit code to seconds per unit
	function automatic logic [SCALE_W-1:0] unit_scale(input logic [1:0] unit);
		logic [SCALE_W-1:0] s;
		case (unit)
			UNIT_SEC:  s = SCALE_SEC;
			UNIT_MIN:  s = SCALE_MIN;
			UNIT_HOUR: s = SCALE_HOUR;
			UNIT_DAY:  s = SCALE_DAY;
			default:   s = SCALE_SEC;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/dss_if.sv
// Valid/ready channel interfaces of the duration string parser.
// Depends on dss_pkg for the status type.
interface dss_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface dss_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] seconds;
	dss_pkg::status_t   status;

	modport source (output valid, seconds, status, input ready);
	modport sink   (input valid, seconds, status, output ready);
endinterface

>>> rtl/duration_string_to_seconds_top.sv
// Duration string parser: characters in, signed seconds and status out.
// Depends on dss_pkg and the channel interfaces in dss_if.sv.
//
// Usage:
//   chars  : one character per transaction, last_char set on the final one.
//   result : one transaction per string, seconds (two's complement, 0 on
//            error) and status (ok, unit without digit, bad unit, overflow).
//   cfg_we / cfg_wdata : write default_unit, the unit applied to a trailing
//            number; write only while no string is in flight.
// Throughput: one character per cycle for any string while results are taken.
// Path: the last character of a string passes the input register, a snapshot
//   of the parse state, the scale product and the result register in turn.
//   The parse state update per character (one constant-scale multiply, an
//   add and a limit compare) is the recurrence registered per character.
// Reset: arst_n clears the parse state, all stage valids and default_unit
//   (seconds); chars.ready is already high when reset is released.
// Stall: while result.ready is low the result holds; characters that are
//   not last keep flowing, and up to two finished strings wait in the
//   internal stages before chars.ready drops.
module duration_string_to_seconds_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata,
	dss_char_if.sink             chars,
	dss_result_if.source         result
);

	localparam int unsigned PROD_W = 32 + dss_pkg::SCALE_W;

	// Configuration and stage registers
	logic [1:0]          du_q;
	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                last_s1;
	dss_pkg::parse_t     st_q;
	dss_pkg::parse_t     nxt;
	logic                valid_s2;
	dss_pkg::parse_t     snap_s2;
	logic                valid_s3;
	logic [PROD_W-1:0]   prod_s3;
	logic [31:0]         total_s3;
	logic                neg_s3;
	logic                seen_s3;
	dss_pkg::status_t    err_s3;
	logic                res_valid_q;
	logic [31:0]         seconds_q;
	dss_pkg::status_t    status_q;

	// Handshake between stages
	logic parse_go;
	logic s2_free;
	logic s3_load;
	logic s3_free;
	logic out_load;

	// Parse datapath
	logic                       is_digit;
	logic                       is_unit;
	logic [dss_pkg::SCALE_W-1:0] sel_scale;
	logic [35:0]                dig_sum;
	logic [PROD_W-1:0]          unit_sum;

	// Finish datapath
	logic [PROD_W-1:0]  fin_sum;
	logic [31:0]        fin_total;
	dss_pkg::status_t   fin_err;
	logic [31:0]        fin_secs;

	assign out_load = valid_s3 && (!res_valid_q || result.ready);
	assign s3_free  = !valid_s3 || out_load;
	assign s3_load  = valid_s2 && s3_free;
	assign s2_free  = !valid_s2 || s3_load;
	assign parse_go = valid_s1 && (!last_s1 || s2_free);
	assign chars.ready = !valid_s1 || parse_go;

	// Hold the default unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			du_q <= dss_pkg::UNIT_SEC;
		end else if (cfg_we) begin
			du_q <= cfg_wdata;
		end
	end

	// Capture the incoming character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	// Decode the character and scale for a unit letter
	always_comb begin
		is_digit = (char_s1 >= dss_pkg::CH_ZERO) && (char_s1 <= dss_pkg::CH_NINE);
		is_unit  = 1'b1;
		case (char_s1)
			dss_pkg::CH_D: sel_scale = dss_pkg::SCALE_DAY;
			dss_pkg::CH_H: sel_scale = dss_pkg::SCALE_HOUR;
			dss_pkg::CH_M: sel_scale = dss_pkg::SCALE_MIN;
			dss_pkg::CH_S: sel_scale = dss_pkg::SCALE_SEC;
			default: begin
				sel_scale = '0;
				is_unit   = 1'b0;
			end
		endcase
		dig_sum  = ({4'b0, st_q.acc} << 3) + ({4'b0, st_q.acc} << 1) + 36'(char_s1[3:0]);
		unit_sum = PROD_W'(st_q.total) + PROD_W'(st_q.acc) * PROD_W'(sel_scale);
	end

	// Advance the parse state by one character; errors freeze it
	always_comb begin
		nxt = st_q;
		if (st_q.err == dss_pkg::ST_OK) begin
			nxt.at_start = 1'b0;
			if (st_q.at_start && char_s1 == dss_pkg::CH_MINUS) begin
				nxt.neg = 1'b1;
			end else if (is_digit) begin
				if (dig_sum > {4'b0, dss_pkg::MAG_LIMIT}) begin
					nxt.err = dss_pkg::ST_OVERFLOW;
				end else begin
					nxt.acc  = dig_sum[31:0];
					nxt.seen = 1'b1;
				end
			end else if (!st_q.seen) begin
				nxt.err = dss_pkg::ST_NO_DIGIT;
			end else if (!is_unit) begin
				nxt.err = dss_pkg::ST_BAD_UNIT;
			end else if (unit_sum > PROD_W'(dss_pkg::MAG_LIMIT)) begin
				nxt.err = dss_pkg::ST_OVERFLOW;
			end else begin
				nxt.total = unit_sum[31:0];
				nxt.acc   = '0;
				nxt.seen  = 1'b0;
			end
		end
	end

	// Update parse state; restart it after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dss_pkg::PARSE_CLEAR;
		end else if (parse_go) begin
			st_q <= last_s1 ? dss_pkg::PARSE_CLEAR : nxt;
		end
	end

	// Snapshot the finished string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= parse_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && parse_go && last_s1) begin
			snap_s2 <= nxt;
		end
	end

	// Scale the trailing number by the default unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_load) begin
			prod_s3  <= PROD_W'(snap_s2.acc) * PROD_W'(dss_pkg::unit_scale(du_q));
			total_s3 <= snap_s2.total;
			neg_s3   <= snap_s2.neg;
			seen_s3  <= snap_s2.seen;
			err_s3   <= snap_s2.err;
		end
	end

	// Add the trailing term, check range and apply the sign
	always_comb begin
		fin_sum   = PROD_W'(total_s3) + prod_s3;
		fin_err   = err_s3;
		fin_total = total_s3;
		if (fin_err == dss_pkg::ST_OK && seen_s3) begin
			if (fin_sum > PROD_W'(dss_pkg::MAG_LIMIT)) begin
				fin_err = dss_pkg::ST_OVERFLOW;
			end else begin
				fin_total = fin_sum[31:0];
			end
		end
		if (fin_err == dss_pkg::ST_OK && !neg_s3 && fin_total[31]) begin
			fin_err = dss_pkg::ST_OVERFLOW;
		end
		if (fin_err != dss_pkg::ST_OK) begin
			fin_secs = '0;
		end else if (neg_s3) begin
			fin_secs = 32'd0 - fin_total;
		end else begin
			fin_secs = fin_total;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || result.ready) begin
			res_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			seconds_q <= fin_secs;
			status_q  <= fin_err;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.seconds = seconds_q;
	assign result.status  = status_q;

endmodule

>>> rtl/dss_checker.sv
// Port-level checks for the duration string parser, bound to the top level.
// Depends on dss_pkg and duration_string_to_seconds_top_macros.svh.
`include "duration_string_to_seconds_top_macros.svh"

module dss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        chars_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_seconds,
	input logic [1:0]  res_status
);

	// A stalled result transaction keeps its payload
	`DSS_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_seconds) && $stable(res_status), "result changed while stalled")

	// Any failed parse reports zero seconds
	`DSS_ASSERT(a_err_zero, res_valid && res_status != dss_pkg::ST_OK |-> res_seconds == 32'd0, "error result with nonzero seconds")

	// Leaving reset: no stale result and the character channel is open
	`DSS_ASSERT_ALWAYS(a_rst_clean, $rose(arst_n) |-> !res_valid && chars_ready, "pipeline not empty after reset")

endmodule

bind duration_string_to_seconds_top dss_checker u_dss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.chars_ready (chars.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_seconds (result.seconds),
	.res_status  (result.status)
);

>>> verif/duration_string_to_seconds_top_tb.sv
// Testbench for the duration string parser: a directed table of characters, then
// random duration strings under several default units, checked against a parse predictor.
// Depends on dss_pkg, the channel interfaces in dss_if.sv and duration_string_to_seconds_top.
module duration_string_to_seconds_top_tb;
	import dss_pkg::*;

	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          N_PHASES     = 5;
	localparam int          PHASE_CHARS  = 280;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          DRAIN_CYCLES = 12;
	localparam int          N_DIRECTED   = 22;
	localparam int          N_BOUNDARY   = 10;
	localparam int          SHOW_LIMIT   = 10;

	typedef struct packed {
		logic signed [31:0] secs;
		status_t            st;
	} duration_t;

	typedef struct packed {
		logic [7:0]         code;
		logic               last;
		logic               typed;
		logic signed [31:0] secs;
		status_t            st;
	} char_row_t;

	// Directed characters; typed rows carry their own expected result
	localparam char_row_t DIRECTED [N_DIRECTED] = '{
		'{8'h00, 1'b1, 1'b1, 32'sd0, ST_NO_DIGIT},
		'{8'hFF, 1'b1, 1'b1, 32'sd0, ST_NO_DIGIT},
		'{CH_MINUS, 1'b1, 1'b1, 32'sd0, ST_OK},
		'{"7", 1'b1, 1'b1, 32'sd7, ST_OK},
		'{"1", 1'b0, 1'b0, 32'sd0, ST_OK},
		'{"x", 1'b1, 1'b1, 32'sd0, ST_BAD_UNIT},
		'{CH_MINUS, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{"3", 1'b0, 1'b0, 32'sd0, ST_OK},
		'{CH_M, 1'b1, 1'b0, 32'sd0, ST_OK},
		'{CH_H, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{"1", 1'b1, 1'b1, 32'sd0, ST_NO_DIGIT},
		'{"2", 1'b0, 1'b0, 32'sd0, ST_OK},
		'{CH_D, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{"4", 1'b0, 1'b0, 32'sd0, ST_OK},
		'{CH_S, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{CH_NINE, 1'b1, 1'b0, 32'sd0, ST_OK},
		'{"2", 1'b0, 1'b0, 32'sd0, ST_OK},
		'{"4", 1'b0, 1'b0, 32'sd0, ST_OK},
		'{"8", 1'b0, 1'b0, 32'sd0, ST_OK},
		'{"5", 1'b0, 1'b0, 32'sd0, ST_OK},
		'{"6", 1'b0, 1'b0, 32'sd0, ST_OK},
		'{CH_D, 1'b1, 1'b1, 32'sd0, ST_OVERFLOW}
	};

	// Default unit of each random phase, both extremes included
	localparam logic [1:0] PHASE_UNIT [N_PHASES] = '{
		UNIT_DAY, UNIT_HOUR, UNIT_SEC, UNIT_MIN, UNIT_DAY
	};

	localparam logic [7:0] UNIT_CHARS [4] = '{CH_D, CH_H, CH_M, CH_S};

	// Numbers around the 2^31 magnitude limit, raw and after unit scaling
	localparam longint unsigned BOUNDARY_VALUES [N_BOUNDARY] = '{
		64'd2147483647, 64'd2147483648, 64'd2147483649, 64'd4294967295,
		64'd35791394, 64'd35791395, 64'd596523, 64'd596524, 64'd24855, 64'd24856
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	dss_char_if   chars_if ();
	dss_result_if result_if ();

	duration_string_to_seconds_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.chars     (chars_if),
		.result    (result_if)
	);

	// Predictor state of the string being parsed
	logic [31:0] dur_acc;
	logic [31:0] dur_total;
	logic        dur_neg;
	logic        dur_seen;
	logic        dur_first;
	status_t     dur_err;
	logic [1:0]  dur_unit;

	duration_t   awaited_durations [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned sent_chars = 0;
	bit          calm = 1'b0;
	bit          hold_kick = 1'b0;
	bit          hold_taken = 1'b0;
	int unsigned hold_left = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned seconds_per_unit(input logic [1:0] unit);
		case (unit)
			UNIT_MIN:  return 64'(SCALE_MIN);
			UNIT_HOUR: return 64'(SCALE_HOUR);
			UNIT_DAY:  return 64'(SCALE_DAY);
			default:   return 64'(SCALE_SEC);
		endcase
	endfunction

	task automatic clear_prediction();
		dur_acc   = '0;
		dur_total = '0;
		dur_neg   = 1'b0;
		dur_seen  = 1'b0;
		dur_first = 1'b1;
		dur_err   = ST_OK;
	endtask

	// Fold the accumulator into the total, scaled to seconds
	task automatic add_unit_term(input longint unsigned scale);
		longint unsigned sum;
		if (!dur_seen) begin
			dur_err = ST_NO_DIGIT;
			return;
		end
		sum = 64'(dur_total) + 64'(dur_acc) * scale;
		if (sum > 64'(MAG_LIMIT)) begin
			dur_err = ST_OVERFLOW;
			return;
		end
		dur_total = sum[31:0];
		dur_acc   = '0;
		dur_seen  = 1'b0;
	endtask

	task automatic parse_char(input logic [7:0] code);
		longint unsigned grown;
		// a leading minus only counts as the first character
		if (dur_first) begin
			dur_first = 1'b0;
			if (code == CH_MINUS) begin
				dur_neg = 1'b1;
				return;
			end
		end
		if (code >= CH_ZERO && code <= CH_NINE) begin
			grown = 64'(dur_acc) * 10 + 64'(code - CH_ZERO);
			if (grown > 64'(MAG_LIMIT)) begin
				dur_err = ST_OVERFLOW;
				return;
			end
			dur_acc  = grown[31:0];
			dur_seen = 1'b1;
			return;
		end
		if (!dur_seen) begin
			dur_err = ST_NO_DIGIT;
			return;
		end
		case (code)
			CH_D:    add_unit_term(64'(SCALE_DAY));
			CH_H:    add_unit_term(64'(SCALE_HOUR));
			CH_M:    add_unit_term(64'(SCALE_MIN));
			CH_S:    add_unit_term(64'(SCALE_SEC));
			default: dur_err = ST_BAD_UNIT;
		endcase
	endtask

	// Advance the predictor by one character; the last one yields a duration
	task automatic predict_char(input logic [7:0] code, input logic last, output bit done,
			output duration_t want);
		done = 1'b0;
		want = '0;
		if (dur_err == ST_OK)
			parse_char(code);
		if (!last)
			return;
		if (dur_err == ST_OK && dur_seen)
			add_unit_term(seconds_per_unit(dur_unit));
		if (dur_err == ST_OK && !dur_neg && dur_total > 32'h7FFF_FFFF)
			dur_err = ST_OVERFLOW;
		if (dur_err == ST_OK)
			want.secs = dur_neg ? 32'd0 - dur_total : dur_total;
		want.st = dur_err;
		done = 1'b1;
		clear_prediction();
	endtask

	// Offer one character, wait for the transaction, then record the expected duration
	task automatic send_char(input logic [7:0] code, input logic last, input logic typed,
			input duration_t typed_want);
		duration_t want;
		bit        done;
		while (!calm && $urandom_range(99) < 19) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= code;
		chars_if.last_char <= last;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		predict_char(code, last, done, want);
		if (done)
			awaited_durations.push_back(typed ? typed_want : want);
		sent_chars++;
	endtask

	// Write the default unit once the block has drained
	task automatic write_default_unit(input logic [1:0] unit);
		while (awaited_durations.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= unit;
		@(posedge clk);
		cfg_we   <= 1'b0;
		dur_unit = unit;
	endtask

	// Build one random string: mostly well-formed, some boundary values, some noise
	task automatic make_duration_string(ref logic [7:0] text [$]);
		int unsigned roll;
		int unsigned groups;
		int unsigned ndig;
		string       num;
		text.delete();
		roll = $urandom_range(99);
		if (roll < 65) begin
			if ($urandom_range(1) == 1)
				text.push_back(CH_MINUS);
			groups = $urandom_range(4, 1);
			for (int g = 0; g < groups; g++) begin
				ndig = ($urandom_range(9) == 0) ? $urandom_range(10, 7) : $urandom_range(4, 1);
				for (int k = 0; k < ndig; k++)
					text.push_back(CH_ZERO + 8'($urandom_range(9)));
				// leave the last group bare now and then for the default unit
				if (g != groups - 1 || $urandom_range(2) != 0)
					text.push_back(UNIT_CHARS[$urandom_range(3)]);
			end
			if ($urandom_range(9) == 0)
				text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
		end else if (roll < 75) begin
			if ($urandom_range(1) == 1)
				text.push_back(CH_MINUS);
			num = $sformatf("%0d", BOUNDARY_VALUES[$urandom_range(N_BOUNDARY - 1)]);
			for (int k = 0; k < num.len(); k++)
				text.push_back(num[k]);
			if ($urandom_range(1) == 1)
				text.push_back(UNIT_CHARS[$urandom_range(3)]);
		end else if (roll < 90) begin
			ndig = $urandom_range(6, 1);
			for (int k = 0; k < ndig; k++)
				text.push_back(8'($urandom_range(255)));
		end else begin
			case ($urandom_range(2))
				0:       text.push_back(CH_MINUS);
				1:       text.push_back(CH_ZERO + 8'($urandom_range(9)));
				default: text.push_back(UNIT_CHARS[$urandom_range(3)]);
			endcase
		end
	endtask

	// Receiver: random stalls, one long hold-off, no stalls during the calm phase
	always @(posedge clk) begin
		if (hold_kick && !hold_taken) begin
			hold_taken       <= 1'b1;
			hold_left        <= HOLD_CYCLES;
			result_if.ready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left        <= hold_left - 1;
			result_if.ready  <= 1'b0;
		end else begin
			result_if.ready  <= calm || ($urandom_range(99) >= 19);
		end
	end

	// Compare each result transaction with the oldest awaited duration
	always @(posedge clk) begin
		duration_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (awaited_durations.size() == 0) begin
				if (mismatch_count < SHOW_LIMIT)
					$display("unexpected result: seconds %0d status %0d",
						result_if.seconds, result_if.status);
				mismatch_count++;
			end else begin
				want = awaited_durations.pop_front();
				if (result_if.seconds !== want.secs || result_if.status !== want.st) begin
					if (mismatch_count < SHOW_LIMIT)
						$display("mismatch: seconds %0d (expected %0d) status %0d (expected %0d)",
							result_if.seconds, want.secs, result_if.status, want.st);
					mismatch_count++;
				end
			end
		end
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		duration_t  row_want;
		logic [7:0] text [$];
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = UNIT_SEC;
		chars_if.valid      = 1'b0;
		chars_if.char_code  = 8'h00;
		chars_if.last_char  = 1'b0;
		result_if.ready     = 1'b0;
		row_want            = '0;
		clear_prediction();
		dur_unit = UNIT_SEC;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed table under the reset default unit
		for (int i = 0; i < N_DIRECTED; i++) begin
			row_want.secs = DIRECTED[i].secs;
			row_want.st   = DIRECTED[i].st;
			send_char(DIRECTED[i].code, DIRECTED[i].last, DIRECTED[i].typed, row_want);
		end

		// random strings, one default unit per phase
		for (int p = 0; p < N_PHASES; p++) begin
			chars_if.valid <= 1'b0;
			write_default_unit(PHASE_UNIT[p]);
			calm <= (p == 1);
			if (p == 2)
				hold_kick <= 1'b1;
			sent_chars = 0;
			while (sent_chars < PHASE_CHARS) begin
				make_duration_string(text);
				foreach (text[k])
					send_char(text[k], k == text.size() - 1, 1'b0, row_want);
			end
		end
		chars_if.valid <= 1'b0;

		// drain, then give any stray result time to show up
		while (awaited_durations.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_durations.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/dss_pkg.sv
rtl/dss_if.sv
rtl/duration_string_to_seconds_top.sv
rtl/dss_checker.sv
verif/duration_string_to_seconds_top_tb.sv
